// File: design/sml_pkg.sv
// sml_pkg: types and constants of the sorted multiset list store
// capacity, count and address widths, command and status codes, transaction structs
// no dependencies
package sml_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FLD_W    = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [FLD_W-1:0]   removed_count;
    logic [FLD_W-1:0]   entry_count;
    logic signed [31:0] smallest;
    logic               empty_res;
  } out_t;

  // zero-extend or truncate a count to the 5-bit result field
  function automatic logic [FLD_W-1:0] to_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+FLD_W-1:0] wide;
    wide = {{FLD_W{1'b0}}, c};
    return wide[FLD_W-1:0];
  endfunction

endpackage

// File: design/sorted_multiset_list_core.sv
// sorted_multiset_list_core: ascending multiset store kept in a synchronous memory
// entries sit in one 1-read 1-write memory, a sequencer walks them per transaction
// depends on sml_pkg
//
// sequence: insert walks down from the top through S_RD and S_CMP, shifting each entry
//   that is not smaller up one slot, then writes the value in S_PUT; delete walks every
//   entry through S_RD and S_CMP, compacting the kept ones; full-store insert and empty-store
//   delete answer from idle; each memory step is a read then a compare/write on the port pair
// throughput: one transaction at a time; busy drops with the result strobe, so the next
//   start is taken at the edge that ends it, and a full-store insert never raises busy
// reset: rst_n clears the count and the sequencer; memory contents are not cleared
module sorted_multiset_list_core
  import sml_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   wr_r, wr_nxt;
  logic signed [31:0] smallest_r, smallest_nxt;
  in_t                req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  logic [31:0]        mem [CAPACITY];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [31:0]        mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [31:0]        rdata_r;

  logic [CNT_W-1:0]   ptr_dec;
  logic [CNT_W-1:0]   ptr_inc;

  assign ptr_dec = ptr_r - CNT_W'(1);
  assign ptr_inc = ptr_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    wr_nxt        = wr_r;
    smallest_nxt  = smallest_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r[ADDR_W-1:0];
    mem_wdata     = rdata_r;
    // insert walks downward, delete walks upward
    mem_raddr     = (req_r.command == CMD_INSERT) ? ptr_dec[ADDR_W-1:0]
                                                  : ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_data;
          ptr_nxt = '0;
          wr_nxt  = '0;
          if (in_data.command == CMD_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              out_valid_nxt         = 1'b1;
              out_nxt.status        = ST_FULL;
              out_nxt.removed_count = '0;
              out_nxt.entry_count   = to_field(count_r);
              out_nxt.smallest      = smallest_r;
              out_nxt.empty_res     = 1'b0;
            end else begin
              ptr_nxt   = count_r;
              state_nxt = (count_r == '0) ? S_PUT : S_RD;
            end
          end else if (count_r == '0) begin
            out_valid_nxt         = 1'b1;
            out_nxt.status        = ST_DONE;
            out_nxt.removed_count = '0;
            out_nxt.entry_count   = '0;
            out_nxt.smallest      = '0;
            out_nxt.empty_res     = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (req_r.command == CMD_INSERT) begin
          if ($signed(rdata_r) >= req_r.value) begin
            // shift this entry up one slot
            mem_we    = 1'b1;
            mem_waddr = ptr_r[ADDR_W-1:0];
            mem_wdata = rdata_r;
            ptr_nxt   = ptr_dec;
            state_nxt = (ptr_r == CNT_W'(1)) ? S_PUT : S_RD;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          if (rdata_r != req_r.value) begin
            mem_we    = 1'b1;
            mem_waddr = wr_r[ADDR_W-1:0];
            mem_wdata = rdata_r;
            wr_nxt    = wr_r + CNT_W'(1);
            if (wr_r == '0) begin
              smallest_nxt = $signed(rdata_r);
            end
          end
          ptr_nxt = ptr_inc;
          if (ptr_inc == count_r) begin
            count_nxt             = wr_nxt;
            out_valid_nxt         = 1'b1;
            out_nxt.status        = ST_DONE;
            out_nxt.removed_count = to_field(count_r - wr_nxt);
            out_nxt.entry_count   = to_field(wr_nxt);
            out_nxt.smallest      = (wr_nxt == '0) ? '0 : smallest_nxt;
            out_nxt.empty_res     = (wr_nxt == '0);
            state_nxt             = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[ADDR_W-1:0];
        mem_wdata = req_r.value;
        count_nxt = count_r + CNT_W'(1);
        if (ptr_r == '0) begin
          smallest_nxt = req_r.value;
        end
        out_valid_nxt         = 1'b1;
        out_nxt.status        = ST_DONE;
        out_nxt.removed_count = '0;
        out_nxt.entry_count   = to_field(count_nxt);
        out_nxt.smallest      = smallest_nxt;
        out_nxt.empty_res     = 1'b0;
        state_nxt             = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r      <= ptr_nxt;
    wr_r       <= wr_nxt;
    smallest_r <= smallest_nxt;
    req_r      <= req_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while still working");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_FULL) |->
      (out_r.removed_count == '0 && count_r == CNT_W'(CAPACITY)))
    else $error("dropped insert with store not full");

  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> (count_r < CNT_W'(CAPACITY) && ptr_r <= count_r))
    else $error("insert slot outside store");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && req_r.command == CMD_DELETE) |=> count_r <= $past(count_r))
    else $error("delete grew the store");

endmodule

// File: sim/tb_sorted_multiset_list_core.sv
// tb_sorted_multiset_list_core: self-checking testbench for the sorted multiset store
// a tracker class predicts every result from its own sorted copy of the store; depends on sml_pkg
// directed corner cases first, then random insert/delete traffic under several sender idle rates
module tb_sorted_multiset_list_core;
  import sml_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SHOW_LIMIT   = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  int idle_pct;
  int stall_cycles = 0;

  class multiset_tracker;
    logic signed [31:0] held_values[$];
    out_t               expected_results[$];
    int unsigned n_inserts, n_deletes, n_full_drops, n_hit_deletes;
    int unsigned n_checked, n_errors, peak;

    task report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= SHOW_LIMIT) $display("mismatch at result %0d: %s", n_checked, msg);
    endtask

    // apply one accepted transaction to the shadow store and queue its result
    function void note_command(input in_t cmd);
      logic signed [31:0] v;
      logic signed [31:0] kept[$];
      out_t want;
      int pos;
      v = cmd.value;
      want = '0;
      want.status = ST_DONE;
      if (cmd.command == CMD_INSERT) begin
        n_inserts++;
        if (held_values.size() >= CAPACITY) begin
          want.status = ST_FULL;
          n_full_drops++;
        end else begin
          pos = 0;
          while (pos < held_values.size() && held_values[pos] < v) pos++;
          held_values.insert(pos, v);
        end
      end else begin
        n_deletes++;
        foreach (held_values[i]) if (held_values[i] != v) kept.push_back(held_values[i]);
        want.removed_count = FLD_W'(held_values.size() - kept.size());
        if (kept.size() != held_values.size()) n_hit_deletes++;
        held_values = kept;
      end
      want.entry_count = FLD_W'(held_values.size());
      want.smallest    = (held_values.size() != 0) ? held_values[0] : 32'sd0;
      want.empty_res   = (held_values.size() == 0);
      if (held_values.size() > peak) peak = held_values.size();
      expected_results.push_back(want);
    endfunction

    task check_result(input out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.removed_count !== want.removed_count)
        report_mismatch($sformatf("removed_count got %0d want %0d",
                                  got.removed_count, want.removed_count));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count got %0d want %0d",
                                  got.entry_count, want.entry_count));
      if (got.smallest !== want.smallest)
        report_mismatch($sformatf("smallest got %0d want %0d", got.smallest, want.smallest));
      if (got.empty_res !== want.empty_res)
        report_mismatch($sformatf("empty_res got %0d want %0d", got.empty_res, want.empty_res));
      n_checked++;
    endtask
  endclass

  multiset_tracker tracker = new();

  sorted_multiset_list_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_cmd(input cmd_t c, input logic signed [31:0] v);
    in_t item;
    item.command = c;
    item.value   = v;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_data);
    if (rst_n && start && !busy) tracker.note_command(in_data);
  end

  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] fill_values[16];
    logic signed [31:0] pool[8];
    logic signed [31:0] v;
    cmd_t c;
    int ins_pct;
    int per_phase;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, duplicates, full store, absent and repeated deletes
    fill_values = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd1,
                    -32'sd2, 32'sh55555555, 32'shAAAAAAAA, 32'sd100, -32'sd100, 32'sd7,
                    32'sd7, 32'sh40000000, 32'shC0000000};
    send_cmd(CMD_DELETE, 32'sd0);
    foreach (fill_values[i]) send_cmd(CMD_INSERT, fill_values[i]);
    send_cmd(CMD_INSERT, 32'sd3);
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_DELETE, 32'sd12345);
    send_cmd(CMD_DELETE, 32'sh80000000);
    send_cmd(CMD_DELETE, 32'sh7FFFFFFF);
    send_cmd(CMD_DELETE, 32'sd7);

    // random: a small value pool per phase so deletes find matches, insert bias in bursts
    per_phase = RANDOM_ITEMS / 4;
    ins_pct   = 50;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: idle_pct = 79;
        2: idle_pct = 29;
        default: idle_pct = 0;
      endcase
      foreach (pool[i]) begin
        case ($urandom_range(3))
          0: pool[i] = $signed($urandom_range(6)) - 32'sd3;
          1: pool[i] = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
          default: pool[i] = $urandom;
        endcase
      end
      for (int k = 0; k < per_phase; k++) begin
        if (k % 40 == 0) begin
          case ($urandom_range(3))
            0: ins_pct = 90;
            1: ins_pct = 60;
            2: ins_pct = 50;
            default: ins_pct = 25;
          endcase
        end
        c = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        if ($urandom_range(99) < 75) v = pool[$urandom_range(7)];
        else v = $urandom;
        send_cmd(c, v);
      end
    end
    idle_pct = 0;
    start <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d inserts and %0d deletes; %0d inserts refused on a full store,",
             tracker.n_inserts, tracker.n_deletes, tracker.n_full_drops);
    $display("%0d deletes found matches, peak occupancy %0d; %0d results checked, %0d mismatches",
             tracker.n_hit_deletes, tracker.peak, tracker.n_checked, tracker.n_errors);
    if (tracker.n_errors == 0 && tracker.expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
